// ===== rtl/core/des_rf_pkg.sv =====
// des round function package: widths and the standard e, s and p tables
`default_nettype none

package des_rf_pkg;

    localparam int HALF_W  = 32;
    localparam int KEY_W   = 48;
    localparam int NUM_BOX = 8;
    localparam int GRP_W   = 6;
    localparam int NIB_W   = 4;

    // source bit index (lsb = 0) in the right half for each expanded bit, msb first
    localparam logic [4:0] E_SRC [KEY_W] = '{
        5'd0,  5'd31, 5'd30, 5'd29, 5'd28, 5'd27,
        5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
        5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19,
        5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15,
        5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11,
        5'd12, 5'd11, 5'd10, 5'd9,  5'd8,  5'd7,
        5'd8,  5'd7,  5'd6,  5'd5,  5'd4,  5'd3,
        5'd4,  5'd3,  5'd2,  5'd1,  5'd0,  5'd31
    };

    // source bit index (lsb = 0) in the s-box word for each output bit, msb first
    localparam logic [4:0] P_SRC [HALF_W] = '{
        5'd16, 5'd25, 5'd12, 5'd11, 5'd3,  5'd20, 5'd4,  5'd15,
        5'd31, 5'd17, 5'd9,  5'd6,  5'd27, 5'd14, 5'd1,  5'd22,
        5'd30, 5'd24, 5'd8,  5'd18, 5'd0,  5'd5,  5'd29, 5'd23,
        5'd13, 5'd19, 5'd2,  5'd26, 5'd10, 5'd21, 5'd28, 5'd7
    };

    // s-boxes, indexed [box][row][column]
    localparam logic [3:0] SBOX [NUM_BOX][4][16] = '{
        '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
            4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
          '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
            4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
          '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
            4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
          '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
            4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
        '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
            4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
          '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
            4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
          '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
            4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
          '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
            4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
        '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
            4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
          '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
            4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
          '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
            4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
          '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
            4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
        '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
            4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
          '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
            4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
          '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
            4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
          '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
            4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
        '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
            4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
          '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
            4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
          '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
            4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
          '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
            4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
        '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
            4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
          '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
            4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
          '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
            4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
          '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
            4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
        '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
            4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
          '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
            4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
          '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
            4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
          '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
            4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
        '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
            4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
          '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
            4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
          '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
            4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
          '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
            4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}
    };

endpackage

`default_nettype wire

// ===== rtl/core/des_rf_expand.sv =====
// stage 1: e expansion of the right half and xor with the round subkey
`default_nettype none

module des_rf_expand (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [des_rf_pkg::HALF_W-1:0] i_right_half,
    input  wire logic [des_rf_pkg::KEY_W-1:0]  i_round_subkey,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [des_rf_pkg::KEY_W-1:0]       o_mixed
);
    import des_rf_pkg::*;

    logic               r_valid;
    logic [KEY_W-1:0]   r_mixed;
    logic [KEY_W-1:0]   n_mixed;
    logic [KEY_W-1:0]   expanded;
    logic               advance;

    always_comb begin
        for (int i = 0; i < KEY_W; i++) begin
            expanded[KEY_W-1-i] = i_right_half[E_SRC[i]];
        end
    end

    assign n_mixed = expanded ^ i_round_subkey;
    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_mixed <= n_mixed;
        end
    end

    assign o_valid = r_valid;
    assign o_mixed = r_mixed;

endmodule

`default_nettype wire

// ===== rtl/core/des_rf_sbox.sv =====
// stage 2: eight parallel s-box lookups
`default_nettype none

module des_rf_sbox (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [des_rf_pkg::KEY_W-1:0]  i_mixed,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [des_rf_pkg::HALF_W-1:0]      o_subst
);
    import des_rf_pkg::*;

    logic               r_valid;
    logic [HALF_W-1:0]  r_subst;
    logic [HALF_W-1:0]  n_subst;
    logic               advance;

    // box 0 takes the top group; row from the outer bits, column from the middle four
    always_comb begin
        logic [GRP_W-1:0] grp;
        grp = '0;
        for (int b = 0; b < NUM_BOX; b++) begin
            grp = i_mixed[KEY_W-1-GRP_W*b -: GRP_W];
            n_subst[HALF_W-1-NIB_W*b -: NIB_W] = SBOX[b][{grp[5], grp[0]}][grp[4:1]];
        end
    end

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_subst <= n_subst;
        end
    end

    assign o_valid = r_valid;
    assign o_subst = r_subst;

endmodule

`default_nettype wire

// ===== rtl/core/des_rf_perm.sv =====
// stage 3: p permutation into the output register
`default_nettype none

module des_rf_perm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [des_rf_pkg::HALF_W-1:0] i_subst,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [des_rf_pkg::HALF_W-1:0]      o_f_result
);
    import des_rf_pkg::*;

    logic               r_valid;
    logic [HALF_W-1:0]  r_f_result;
    logic [HALF_W-1:0]  n_f_result;
    logic               advance;

    always_comb begin
        for (int i = 0; i < HALF_W; i++) begin
            n_f_result[HALF_W-1-i] = i_subst[P_SRC[i]];
        end
    end

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_f_result <= n_f_result;
        end
    end

    assign o_valid    = r_valid;
    assign o_f_result = r_f_result;

endmodule

`default_nettype wire

// ===== rtl/core/des_round_function.sv =====
// des round function f(r, k): three-stage pipeline top level
//
//   channel  direction  handshake                  word
//   in       input      i_in_valid / o_in_ready    i_right_half, i_round_subkey
//   out      output     o_out_valid / i_out_ready  o_f_result
//
// a word accepted at the input is registered in turn by the three register stages
// (expand/xor, s-box, p perm) and leaves from the last one; one word per cycle
// is sustained while the output is not stalled.
// reset is synchronous and active low; it clears only the stage valid bits
// a stalled output freezes the stages behind it, and ready ripples back
// through them so an empty stage still takes a word; nothing is lost or repeated
`default_nettype none

module des_round_function (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [des_rf_pkg::HALF_W-1:0] i_right_half,
    input  wire logic [des_rf_pkg::KEY_W-1:0]  i_round_subkey,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [des_rf_pkg::HALF_W-1:0]      o_f_result
);
    import des_rf_pkg::*;

    // stage 1 to stage 2
    logic               s1_valid;
    logic               s1_ready;
    logic [KEY_W-1:0]   s1_mixed;

    // stage 2 to stage 3
    logic               s2_valid;
    logic               s2_ready;
    logic [HALF_W-1:0]  s2_subst;

    // e expansion and subkey mix
    des_rf_expand u_expand (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_right_half   (i_right_half),
        .i_round_subkey (i_round_subkey),
        .o_valid        (s1_valid),
        .i_ready        (s1_ready),
        .o_mixed        (s1_mixed)
    );

    // substitution through the eight s-boxes
    des_rf_sbox u_sbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_mixed (s1_mixed),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_subst (s2_subst)
    );

    // p permutation, last stage doubles as the output register
    des_rf_perm u_perm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s2_valid),
        .o_ready    (s2_ready),
        .i_subst    (s2_subst),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_f_result (o_f_result)
    );

    // sync reset leaves the pipe empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !s1_valid && !s2_valid))
        else $error("pipeline not empty after reset");

    // a full pipe with a stalled output must refuse new words
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s2_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline full and stalled");

    // an accepted word shows up in stage 1 on the next cycle
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> s1_valid)
        else $error("accepted word missing from stage 1");

    // a stage 2 word held back by stage 3 keeps its value
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_subst)))
        else $error("stalled stage 2 word changed or dropped");

endmodule

`default_nettype wire

// ===== tb/sv/des_round_function_tb_pkg.sv =====
`timescale 1ns / 100ps
// round function predictor and result scoreboard for the des round function bench
package des_f_check_pkg;

    // e selection, des numbering (1 = msb of the right half), msb of the result first
    localparam int unsigned EXP_SEL [48] = '{
        32, 1,  2,  3,  4,  5,
        4,  5,  6,  7,  8,  9,
        8,  9,  10, 11, 12, 13,
        12, 13, 14, 15, 16, 17,
        16, 17, 18, 19, 20, 21,
        20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29,
        28, 29, 30, 31, 32, 1
    };

    // p permutation, des numbering of the s-box word
    localparam int unsigned PERM_SEL [32] = '{
        16, 7,  20, 21, 29, 12, 28, 17,
        1,  15, 23, 26, 5,  18, 31, 10,
        2,  8,  24, 14, 32, 27, 3,  9,
        19, 13, 30, 6,  22, 11, 4,  25
    };

    // one word per box row, column 0 in the top nibble; index is box * 4 + row
    localparam logic [63:0] SBOX_ROWS [32] = '{
        64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538,
        64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
        64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5,
        64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
        64'hA09E63F51DC7B428, 64'hD709346A285ECBF1,
        64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
        64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9,
        64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
        64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986,
        64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
        64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38,
        64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
        64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86,
        64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
        64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92,
        64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
    };

    function automatic logic [31:0] feistel_f(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] mixed;
        logic [31:0] boxed;
        logic [31:0] f;
        logic [5:0]  grp;
        logic [63:0] row_word;
        int          row;
        int          col;
        for (int i = 0; i < 48; i++) begin
            mixed[47-i] = r[32-EXP_SEL[i]];
        end
        mixed = mixed ^ k;
        for (int b = 0; b < 8; b++) begin
            grp = mixed[47-6*b -: 6];
            row = {grp[5], grp[0]};
            col = grp[4:1];
            row_word = SBOX_ROWS[b*4+row];
            boxed[31-4*b -: 4] = row_word[63-4*col -: 4];
        end
        for (int i = 0; i < 32; i++) begin
            f[31-i] = boxed[32-PERM_SEL[i]];
        end
        return f;
    endfunction

    typedef struct {
        logic [31:0] r;
        logic [47:0] k;
        logic [31:0] f;
    } t_f_expect;

    class round_f_tracker;
        t_f_expect   expected_f [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void report_mismatch(input string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endfunction

        function void note_input(input logic [31:0] r, input logic [47:0] k);
            t_f_expect e;
            e.r = r;
            e.k = k;
            e.f = feistel_f(r, k);
            expected_f.push_back(e);
        endfunction

        function void check_result(input logic [31:0] got);
            t_f_expect e;
            if (expected_f.size() == 0) begin
                report_mismatch($sformatf("f_result %h with nothing outstanding", got));
            end else begin
                e = expected_f.pop_front();
                if (got !== e.f) begin
                    report_mismatch($sformatf("f_result got %h want %h (r %h k %h)",
                                              got, e.f, e.r, e.k));
                end
            end
        endfunction

        function int unsigned pending();
            return expected_f.size();
        endfunction

        function void flush_leftovers();
            t_f_expect e;
            while (expected_f.size() != 0) begin
                e = expected_f.pop_front();
                report_mismatch($sformatf("no f_result for r %h k %h", e.r, e.k));
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/des_round_function_tb.sv =====
`timescale 1ns / 100ps
// top-level bench for des_round_function: random and directed words checked against a predictor
module des_round_function_tb;

    import des_f_check_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1200;
    localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no handshake on either side
    localparam int unsigned DRAIN_CYCLES = 8;     // pipeline is three deep, leave some margin

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_right_half   = '0;
    logic [47:0] i_round_subkey = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [31:0] o_f_result;

    // when set, neither side inserts bubbles or stalls
    logic        calm = 1'b0;
    int unsigned stalled_cycles = 0;

    round_f_tracker tracker = new();

    des_round_function i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_right_half   (i_right_half),
        .i_round_subkey (i_round_subkey),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_f_result     (o_f_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure, changed on the falling edge only
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 33);
    end

    // monitor: note accepted words first, then check results, all on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.note_input(i_right_half, i_round_subkey);
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_result(o_f_result);
            end
            // watchdog: any handshake restarts the count
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("des_round_function test failed");
                $finish;
            end
        end
    end

    // present one word, with random bubbles ahead of it; returns at the accepting edge
    task automatic send_word(input logic [31:0] r, input logic [47:0] k);
        while (!calm && $urandom_range(99) < 33) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_right_half   <= r;
        i_round_subkey <= k;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    initial begin
        logic [63:0] wide;
        logic [31:0] r;
        int unsigned pick;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single bits at both ends, and words that force
        // every box into each of its four rows
        send_word(32'h0000_0000, 48'h0000_0000_0000);        // row 0, column 0 everywhere
        send_word(32'hFFFF_FFFF, 48'h0000_0000_0000);        // row 3, column 15 everywhere
        send_word(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_word(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_word(32'h0000_0000, {8{6'b000001}});            // row 1 everywhere
        send_word(32'h0000_0000, {8{6'b100000}});            // row 2 everywhere
        send_word(32'h0000_0000, {8{6'b011110}});            // row 0, column 15
        send_word(32'hAAAA_AAAA, 48'h5555_5555_5555);
        send_word(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        send_word(32'h0000_0001, 48'h0000_0000_0000);        // last bit wraps to both ends
        send_word(32'h8000_0000, 48'h0000_0000_0000);        // first bit wraps too
        send_word(32'h0000_0000, 48'h0000_0000_0001);
        send_word(32'h0000_0000, 48'h8000_0000_0000);
        send_word(32'h0F0F_0F0F, 48'hF0F0_F0F0_F0F0);
        send_word(32'h1234_5678, 48'hFEDC_BA98_7654);

        // random: mostly full-range words, some with a zero key or a sparse half;
        // a middle stretch runs back to back with no stalls
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 400 && n < 700);
            pick = $urandom_range(9);
            wide = {$urandom(), $urandom()};
            r    = $urandom();
            case (pick)
                0: begin
                    send_word(r, 48'h0000_0000_0000);
                end
                1: begin
                    send_word(r & $urandom() & $urandom(), wide[47:0]);
                end
                default: begin
                    send_word(r, wide[47:0]);
                end
            endcase
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain, then give the pipe a few more cycles to show any stray word
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.flush_leftovers();

        if (tracker.mismatches == 0) begin
            $display("des_round_function test passed");
        end else begin
            $display("des_round_function test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/des_rf_pkg.sv
rtl/core/des_rf_expand.sv
rtl/core/des_rf_sbox.sv
rtl/core/des_rf_perm.sv
rtl/core/des_round_function.sv
tb/sv/des_round_function_tb_pkg.sv
tb/sv/des_round_function_tb.sv
